>>> hdl/sksp_pkg.sv
// Package for the stable key sorter: record type, cell control struct, widths.
// Used by sksp_cell and stable_key_sort_with_payload.
`default_nettype none
package sksp_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned KeyW         = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned DataW        = KeyW + 2 * WordW;

  typedef struct packed {
    logic signed [WordW-1:0] y;
    logic signed [WordW-1:0] x;
    logic        [KeyW-1:0]  key;
  } rec_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage
`default_nettype wire

>>> hdl/sksp_cell.sv
// One cell of the insertion chain: holds one record, inserts or shifts it on.
// Depends on sksp_pkg.
`default_nettype none
module sksp_cell
  import sksp_pkg::*;
(
  input  wire        clk_i,
  input  wire  cell_ctrl_t ctrl_i,
  input  wire        occupied_i,
  input  wire  rec_t new_rec_i,
  input  wire  rec_t prev_rec_i,
  input  wire        prev_gt_i,
  input  wire  rec_t next_rec_i,
  output rec_t       rec_o,
  output logic       gt_o
);

  rec_t rec_q, rec_d;

  assign gt_o  = !occupied_i || (rec_q.key > new_rec_i.key);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.load && gt_o) begin
      rec_d = prev_gt_i ? prev_rec_i : new_rec_i;
    end else if (ctrl_i.shift) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule
`default_nettype wire

>>> hdl/stable_key_sort_with_payload.sv
// Stable ascending sorter for records of a 16-bit key and two 32-bit payload
// words, built as a chain of DEPTH insertion cells; depends on sksp_pkg, sksp_cell.
// Records stream in at one per cycle; each is inserted at once into its sorted
// place (after any equal keys) while larger keys shift one cell along. The
// record with tlast closes the set; from the next cycle the set leaves from the
// chain head at one record per cycle while m_axis_tready is high, and no input
// is taken while a set is leaving. Records beyond DEPTH are dropped and tuser
// is set on every record of that set. No clearing pass is needed after reset.
`default_nettype none
module stable_key_sort_with_payload
  import sksp_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire  [DataW-1:0] s_axis_tdata,   // time_key[15:0], x_coord[47:16], y_coord[79:48]
  input  wire              s_axis_tlast,   // last_in
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // sorted_key[15:0], sorted_x[47:16], sorted_y[79:48]
  output logic             m_axis_tlast,   // last_out
  output logic             m_axis_tuser    // overflow
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            s_xfer, m_xfer, full;
  cell_ctrl_t      ctrl;
  rec_t            new_rec;
  rec_t            cell_rec [DEPTH];
  logic            cell_gt  [DEPTH];

  assign new_rec       = rec_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  assign full          = (count_q == CntW'(DEPTH));
  assign ctrl.load     = s_xfer && !full;
  assign ctrl.shift    = m_xfer;

  assign m_axis_tdata  = DataW'(cell_rec[0]);
  assign m_axis_tlast  = (count_q == CntW'(1));
  assign m_axis_tuser  = drop_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_gt;
    if (i == 0) begin : g_head
      assign prev_rec = new_rec;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_rec = cell_rec[i-1];
      assign prev_gt  = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_rec = cell_rec[i];
    end else begin : g_mid
      assign next_rec = cell_rec[i+1];
    end
    sksp_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CntW'(i) < count_q),
      .new_rec_i  (new_rec),
      .prev_rec_i (prev_rec),
      .prev_gt_i  (prev_gt),
      .next_rec_i (next_rec),
      .rec_o      (cell_rec[i]),
      .gt_o       (cell_gt[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drop_d  = drop_q;
    case (state_q)
      ST_LOAD: begin
        if (s_xfer) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (m_xfer) begin
          count_d = count_q - CntW'(1);
          if (m_axis_tlast) begin
            state_d = ST_LOAD;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
        count_d = '0;
        drop_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_q != '0)
    else $error("emitting from an empty chain");

  a_close_starts_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tlast |=> m_axis_tvalid && !s_axis_tready)
    else $error("closing transfer did not start output");

  a_keys_ascend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=>
      m_axis_tdata[KeyW-1:0] >= $past(m_axis_tdata[KeyW-1:0]))
    else $error("output keys out of order");

  a_flag_steady : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> $stable(m_axis_tuser))
    else $error("overflow flag changed within a run");

endmodule
`default_nettype wire

>>> test/tb_stable_key_sort_with_payload.sv
// Testbench for stable_key_sort_with_payload: streams record sets, predicts the stable
// ascending order with the drop flag, and checks every sorted record field by field.
// Depends on sksp_pkg and the sorter RTL.
`default_nettype none
module tb_stable_key_sort_with_payload
  import sksp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    rec_t rec;
    logic last;
  } rec_item_t;

  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_rec_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  wire              s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  wire              m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  wire  [DataW-1:0] m_axis_tdata;
  wire              m_axis_tlast;
  wire              m_axis_tuser;

  rec_item_t   record_q[$];
  sorted_rec_t sorted_exp_q[$];
  rec_t        run_buf[DEPTH];
  int unsigned run_n = 0;
  logic        run_dropped = 1'b0;
  rec_item_t   drv_item;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned err_cnt = 0;

  stable_key_sort_with_payload #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  function automatic logic idle_now();
    logic calm;
    calm = (cyc >= 600) && (cyc < 1000);
    return !calm && ($urandom_range(99) < 33);
  endfunction

  // Insert after any equal keys, drop once full; emit the run on the closing record.
  task automatic absorb_record(input rec_t r, input logic last);
    int unsigned j;
    sorted_rec_t o;
    if (run_n < DEPTH) begin
      j = run_n;
      while (j > 0 && run_buf[j-1].key > r.key) begin
        run_buf[j] = run_buf[j-1];
        j--;
      end
      run_buf[j] = r;
      run_n++;
    end else begin
      run_dropped = 1'b1;
    end
    if (last) begin
      for (int unsigned k = 0; k < run_n; k++) begin
        o.rec  = run_buf[k];
        o.last = (k + 1 == run_n);
        o.ovf  = run_dropped;
        sorted_exp_q.push_back(o);
      end
      run_n = 0;
      run_dropped = 1'b0;
    end
  endtask

  task automatic add_record(input logic [15:0] key, input logic [31:0] x,
                            input logic [31:0] y, input logic last);
    rec_item_t it;
    it.rec.key = key;
    it.rec.x   = x;
    it.rec.y   = y;
    it.last    = last;
    record_q.push_back(it);
  endtask

  task automatic add_random_set(input int unsigned n);
    logic [15:0] key;
    int unsigned mode;
    for (int unsigned i = 0; i < n; i++) begin
      mode = $urandom_range(3);
      if (mode < 2) key = 16'($urandom_range(7));
      else if (mode == 2) key = 16'($urandom);
      else key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      add_record(key, $urandom, $urandom, i + 1 == n);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_record(rec_t'(s_axis_tdata), s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (record_q.size() > 0 && !idle_now()) begin
          drv_item = record_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_item.rec;
          s_axis_tlast  <= drv_item.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Hold off once while a large run is leaving, so input stalls behind it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && m_axis_tvalid && sorted_exp_q.size() > 30) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 400;
      hold_done     <= 1'b1;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= !idle_now();
    end
  end

  always @(posedge clk_i) begin : monitor
    rec_t        got;
    sorted_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (sorted_exp_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $realtime,
                 m_axis_tdata);
        err_cnt++;
      end else begin
        want = sorted_exp_q.pop_front();
        check_field("sorted_key", 32'(want.rec.key), 32'(got.key));
        check_field("sorted_x", want.rec.x, got.x);
        check_field("sorted_y", want.rec.y, got.y);
        check_field("last_out", 32'(want.last), 32'(m_axis_tlast));
        check_field("overflow", 32'(want.ovf), 32'(m_axis_tuser));
      end
    end
  end

  initial begin
    int unsigned set_idx;
    // single records at the key and payload extremes
    add_record(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_record(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // equal keys must keep arrival order
    add_record(16'd5, 32'd0, 32'hA0, 1'b0);
    add_record(16'd5, 32'd1, 32'hA1, 1'b0);
    add_record(16'd3, 32'd2, 32'hA2, 1'b0);
    add_record(16'd5, 32'd3, 32'hA3, 1'b0);
    add_record(16'h0000, 32'd4, 32'hA4, 1'b0);
    add_record(16'hFFFF, 32'd5, 32'hA5, 1'b0);
    add_record(16'd3, 32'd6, 32'hA6, 1'b1);
    // descending keys
    for (int i = 9; i >= 4; i--) begin
      add_record(16'(i), 32'(i), 32'hFFFF_FFFF - 32'(i), i == 4);
    end
    // already in order
    add_record(16'd1, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_record(16'd2, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_record(16'd3, 32'hFFFF_FFFF, 32'h0, 1'b1);

    // random sets; one closes on a dropped record, one fills exactly, one spills over
    set_idx = 0;
    while (record_q.size() < 270) begin
      if (set_idx == 2) add_random_set(DEPTH + 1);
      else if (set_idx == 5) add_random_set(DEPTH);
      else if (set_idx == 8) add_random_set($urandom_range(DEPTH + 2, DEPTH + 8));
      else add_random_set($urandom_range(1, 10));
      set_idx++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (record_q.size() == 0 && !s_axis_tvalid);
    wait (sorted_exp_q.size() == 0);
    repeat (DEPTH + 20) @(posedge clk_i);
    if (err_cnt == 0 && sorted_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
